@@ src/quadratic_root_solver_unit_defines.svh @@
// assertion helpers for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every clock edge outside reset
`define QRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/qrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_BITS     = 32;

  typedef enum logic [1:0] {
    ST_REAL  = 2'd0,
    ST_NONE  = 2'd1,
    ST_AZERO = 2'd2
  } status_e;

endpackage

@@ src/qrs_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int XW = 66,
  parameter int TW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [XW-1:0]       x_i,
  input  logic [TW-1:0]       tag_i,
  output logic                valid_o,
  output logic [XW/2-1:0]     root_o,
  output logic [TW-1:0]       tag_o
);

  localparam int RW = XW / 2;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [RW+1:0] rem;
    logic [RW-1:0] root;
  } step_t;

  function automatic step_t sq_step(step_t p);
    logic [RW+3:0] r2;
    logic [RW+3:0] t;
    step_t         n;
    r2  = {p.rem, p.x[XW-1 -: 2]};
    t   = (RW+4)'({p.root, 2'b01});
    n.x = p.x << 2;
    if (r2 >= t) begin
      n.rem  = (RW+2)'(r2 - t);
      n.root = {p.root[RW-2:0], 1'b1};
    end else begin
      n.rem  = (RW+2)'(r2);
      n.root = {p.root[RW-2:0], 1'b0};
    end
    return n;
  endfunction

  step_t         st_q  [RW];
  logic [TW-1:0] tag_q [RW];
  logic [RW-1:0] vld_q;
  step_t         init;

  assign init = '{x: x_i, rem: '0, root: '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= sq_step(init);
      tag_q[0] <= tag_i;
      for (int k = 1; k < RW; k++) begin
        st_q[k]  <= sq_step(st_q[k-1]);
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = st_q[RW-1].root;
  assign tag_o   = tag_q[RW-1];

endmodule

@@ src/qrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NW  = 35,
  parameter int DVW = 17,
  parameter int TW  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DVW-1:0] den_i,
  input  logic [TW-1:0]  tag_i,
  output logic           valid_o,
  output logic [NW-1:0]  quot_o,
  output logic [TW-1:0]  tag_o
);

  typedef struct packed {
    logic [NW-1:0]  n;
    logic [DVW-1:0] rem;
    logic [DVW-1:0] d;
  } step_t;

  function automatic step_t dv_step(step_t p);
    logic [DVW:0] r2;
    logic         qb;
    step_t        n;
    r2  = {p.rem, p.n[NW-1]};
    n.d = p.d;
    qb  = (r2 >= {1'b0, p.d});
    if (qb) begin
      n.rem = DVW'(r2 - {1'b0, p.d});
    end else begin
      n.rem = DVW'(r2);
    end
    n.n = {p.n[NW-2:0], qb};
    return n;
  endfunction

  step_t         st_q  [NW];
  logic [TW-1:0] tag_q [NW];
  logic [NW-1:0] vld_q;
  step_t         init;

  assign init = '{n: num_i, rem: '0, d: den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= dv_step(init);
      tag_q[0] <= tag_i;
      for (int k = 1; k < NW; k++) begin
        st_q[k]  <= dv_step(st_q[k-1]);
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = st_q[NW-1].n;
  assign tag_o   = tag_q[NW-1];

endmodule

@@ src/quadratic_root_solver_unit.sv @@
`timescale 1ns / 1ps
`include "quadratic_root_solver_unit_defines.svh"
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Real roots of a*x^2 + b*x + c in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_ready_o carries one coefficient set
// (coef_a_i, coef_b_i, coef_c_i) per transaction. Output channel
// out_valid_o / out_ready_i carries root_plus_o, root_minus_o, status_o and
// saturated_o, one transaction per input, in input order.
// Throughput: one transaction per cycle while the receiver keeps up.
// Each set passes through stage 1 (magnitudes and products), stage 2
// (discriminant), the bit-per-stage square root, stage 3 (numerators), the
// two bit-per-stage dividers side by side and the output register.
// Status 2 (a is zero) and status 1 (negative discriminant) give zero roots.
// Reset clears all valid bits; the pipeline holds no other state.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
  parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [COEF_BITS-1:0] coef_a_i,
  input  logic signed [COEF_BITS-1:0] coef_b_i,
  input  logic signed [COEF_BITS-1:0] coef_c_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [qrs_pkg::ROOT_BITS-1:0] root_plus_o,
  output logic signed [qrs_pkg::ROOT_BITS-1:0] root_minus_o,
  output logic [1:0]                  status_o,
  output logic                        saturated_o
);

  import qrs_pkg::*;

  localparam int CB   = COEF_BITS;
  localparam int DW   = 2 * CB + 1;
  localparam int XW   = DW + 2 * FRAC_BITS;
  localparam int XW2  = XW + (XW % 2);
  localparam int RW   = XW2 / 2;
  localparam int NBW  = CB + FRAC_BITS + 1;
  localparam int NW1  = ((NBW > RW + 1) ? NBW : RW + 1) + 1;
  localparam int QW   = (NW1 > 33) ? NW1 : 33;
  localparam int DVW  = CB + 1;
  localparam int TW   = 2 + NBW + 1 + DVW;
  localparam logic [QW-1:0] MAX_POS = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] MAX_NEG = QW'(64'h8000_0000);

  function automatic logic [32:0] clip(logic [NW1-1:0] q, logic neg);
    logic [QW-1:0] qe;
    logic [QW-1:0] ng;
    logic [32:0]   r;
    qe = QW'(q);
    ng = -qe;
    if (neg) begin
      if (qe > MAX_NEG) r = {1'b1, 32'h8000_0000};
      else              r = {1'b0, ng[31:0]};
    end else begin
      if (qe > MAX_POS) r = {1'b1, 32'h7FFF_FFFF};
      else              r = {1'b0, qe[31:0]};
    end
    return r;
  endfunction

  logic en;

  // stage 1: magnitudes and products
  logic [CB-1:0]   amag_d, bmag_d, cmag_d;
  logic            s1_vld_q;
  logic [2*CB-1:0] s1_bb_q, s1_ac_q;
  logic            s1_acpos_q, s1_azero_q, s1_aneg_q;
  logic [CB-1:0]   s1_amag_q;
  logic signed [CB-1:0] s1_b_q;

  // stage 2: discriminant
  logic [2*CB+1:0] four_ac, bb_ext;
  logic            disc_neg;
  logic [DW-1:0]   disc;
  status_e         st2;
  logic signed [NBW-1:0] nb;
  logic            s2_vld_q;
  logic [XW2-1:0]  s2_x_q;
  logic [TW-1:0]   s2_tag_q;

  // square root
  logic            sq_vld;
  logic [RW-1:0]   sq_root;
  logic [TW-1:0]   sq_tag;
  logic signed [NBW-1:0] sq_nb;
  logic signed [NW1-1:0] np, nm;

  // stage 3: numerators
  logic            s3_vld_q;
  logic [NW1-1:0]  s3_np_q, s3_nm_q;
  logic            s3_sp_q, s3_sm_q;
  logic [DVW-1:0]  s3_dv_q;
  logic [1:0]      s3_st_q;

  // dividers
  logic            dp_vld, dm_vld;
  logic [NW1-1:0]  dp_q, dm_q;
  logic [2:0]      dp_tag;
  logic            dm_tag;
  logic [32:0]     cp, cm;

  // output register
  logic            out_vld_q;
  logic [31:0]     rp_q, rm_q;
  logic [1:0]      st_q;
  logic            sat_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign amag_d = coef_a_i[CB-1] ? CB'(~coef_a_i + CB'(1)) : coef_a_i;
  assign bmag_d = coef_b_i[CB-1] ? CB'(~coef_b_i + CB'(1)) : coef_b_i;
  assign cmag_d = coef_c_i[CB-1] ? CB'(~coef_c_i + CB'(1)) : coef_c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= sq_vld;
      out_vld_q <= dp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bb_q    <= (2*CB)'(bmag_d) * (2*CB)'(bmag_d);
      s1_ac_q    <= (2*CB)'(amag_d) * (2*CB)'(cmag_d);
      s1_acpos_q <= (coef_a_i != '0) && (coef_c_i != '0) &&
                    (coef_a_i[CB-1] == coef_c_i[CB-1]);
      s1_azero_q <= (coef_a_i == '0);
      s1_aneg_q  <= coef_a_i[CB-1];
      s1_amag_q  <= amag_d;
      s1_b_q     <= coef_b_i;
    end
  end

  always_comb begin
    four_ac  = {s1_ac_q, 2'b00};
    bb_ext   = (2*CB+2)'(s1_bb_q);
    disc_neg = s1_acpos_q && (four_ac > bb_ext);
    if (s1_acpos_q) disc = DW'(bb_ext - four_ac);
    else            disc = DW'(bb_ext + four_ac);
    if (s1_azero_q)    st2 = ST_AZERO;
    else if (disc_neg) st2 = ST_NONE;
    else               st2 = ST_REAL;
    nb = -(NBW'(s1_b_q) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q   <= XW2'(disc) << (2 * FRAC_BITS);
      s2_tag_q <= {st2, nb, s1_aneg_q, DVW'({s1_amag_q, 1'b0})};
    end
  end

  qrs_sqrt #(
    .XW (XW2),
    .TW (TW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .x_i     (s2_x_q),
    .tag_i   (s2_tag_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign sq_nb = sq_tag[TW-3 -: NBW];
  assign np    = NW1'(sq_nb) + NW1'($signed({1'b0, sq_root}));
  assign nm    = NW1'(sq_nb) - NW1'($signed({1'b0, sq_root}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_np_q <= np[NW1-1] ? NW1'(-np) : NW1'(np);
      s3_nm_q <= nm[NW1-1] ? NW1'(-nm) : NW1'(nm);
      s3_sp_q <= np[NW1-1] ^ sq_tag[DVW];
      s3_sm_q <= nm[NW1-1] ^ sq_tag[DVW];
      s3_dv_q <= sq_tag[DVW-1:0];
      s3_st_q <= sq_tag[TW-1 -: 2];
    end
  end

  qrs_div #(
    .NW  (NW1),
    .DVW (DVW),
    .TW  (3)
  ) u_div_plus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .num_i   (s3_np_q),
    .den_i   (s3_dv_q),
    .tag_i   ({s3_st_q, s3_sp_q}),
    .valid_o (dp_vld),
    .quot_o  (dp_q),
    .tag_o   (dp_tag)
  );

  qrs_div #(
    .NW  (NW1),
    .DVW (DVW),
    .TW  (1)
  ) u_div_minus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .num_i   (s3_nm_q),
    .den_i   (s3_dv_q),
    .tag_i   (s3_sm_q),
    .valid_o (dm_vld),
    .quot_o  (dm_q),
    .tag_o   (dm_tag)
  );

  assign cp = clip(dp_q, dp_tag[0]);
  assign cm = clip(dm_q, dm_tag);

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= dp_tag[2:1];
      if (status_e'(dp_tag[2:1]) == ST_REAL) begin
        rp_q  <= cp[31:0];
        rm_q  <= cm[31:0];
        sat_q <= cp[32] | cm[32];
      end else begin
        rp_q  <= '0;
        rm_q  <= '0;
        sat_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign root_plus_o  = rp_q;
  assign root_minus_o = rm_q;
  assign status_o     = st_q;
  assign saturated_o  = sat_q;

  `QRS_ASSERT_IMPL(a_lanes_lockstep, 1'b1, dp_vld == dm_vld, "divider lanes out of step")
  `QRS_ASSERT_IMPL(a_no_root_zero, out_valid_o && (status_o != ST_REAL),
    (root_plus_o == 0) && (root_minus_o == 0) && !saturated_o, "roots set without real status")
  `QRS_ASSERT_IMPL(a_sat_at_limit, out_valid_o && saturated_o,
    (root_plus_o == 32'sh7FFF_FFFF) || (root_plus_o == 32'sh8000_0000) ||
    (root_minus_o == 32'sh7FFF_FFFF) || (root_minus_o == 32'sh8000_0000),
    "saturated flag without clipped root")
  `QRS_ASSERT_IMPL(a_stall_blocks, out_valid_o && !out_ready_i, !in_ready_o,
    "input taken while output stalled")

endmodule

@@ test/qrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Watches both channels of the quadratic root solver, predicts the roots of
// every accepted coefficient set and compares each result field by field.
// ----------------------------------------------------------------------------
module qrs_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [15:0]            coef_a_i,
  input  logic signed [15:0]            coef_b_i,
  input  logic signed [15:0]            coef_c_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [qrs_pkg::ROOT_BITS-1:0] root_plus_i,
  input  logic signed [qrs_pkg::ROOT_BITS-1:0] root_minus_i,
  input  logic [1:0]                    status_i,
  input  logic                          saturated_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);
  import qrs_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [31:0] rp;
    logic signed [31:0] rm;
    status_e            st;
    logic               sat;
  } roots_t;

  roots_t root_q[$];
  int     mismatches;

  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip(longint q, inout logic sat);
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                         logic signed [15:0] cc);
    roots_t      res;
    longint      a, b, c, disc, s, nb, den;
    logic        sat;
    logic [127:0] wide;
    res = '0;
    res.st = ST_REAL;
    a = ca; b = cb; c = cc;
    sat = 1'b0;
    if (a == 0) begin
      res.st = ST_AZERO;
      return res;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      res.st = ST_NONE;
      return res;
    end
    wide = {64'd0, disc} << (2 * FRAC);
    s = longint'(isqrt128(wide));
    nb = -b * (64'sd1 <<< FRAC);
    den = 2 * a;
    res.rp = clip((nb + s) / den, sat);
    res.rm = clip((nb - s) / den, sat);
    res.sat = sat;
    return res;
  endfunction

  assign pending_o = root_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    roots_t exp_r;
    if (!rst_ni) begin
      root_q.delete();
      fail_cnt_o <= 0;
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) root_q.push_back(solve_roots(coef_a_i, coef_b_i, coef_c_i));
      if (out_valid_i && out_ready_i) begin
        if (root_q.size() == 0) begin
          fail_cnt_o <= fail_cnt_o + 1;
          if (mismatches < 10) $display("ERROR: result with nothing expected");
          mismatches++;
        end else begin
          exp_r = root_q.pop_front();
          if (root_plus_i !== exp_r.rp || root_minus_i !== exp_r.rm ||
              status_i !== exp_r.st || saturated_i !== exp_r.sat) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (mismatches < 10)
              $display("ERROR: exp rp=%0d rm=%0d st=%0d sat=%0d, got rp=%0d rm=%0d st=%0d sat=%0d",
                       exp_r.rp, exp_r.rm, exp_r.st, exp_r.sat,
                       root_plus_i, root_minus_i, status_i, saturated_i);
            mismatches++;
          end
        end
      end
    end
  end
endmodule

@@ test/quadratic_root_solver_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_tb
// Drives directed and random coefficient sets with random gaps and output
// stalls, including a long receiver hold; qrs_checker scores the results.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit_tb;
  import qrs_pkg::*;

  localparam int NUM_RANDOM = 1500;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [15:0] coef_a_i, coef_b_i, coef_c_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [ROOT_BITS-1:0] root_plus_o, root_minus_o;
  logic [1:0] status_o;
  logic saturated_o;
  int   fail_cnt;
  int   pending;
  int   cycles;
  bit   hold_req;
  bit   no_idle;

  quadratic_root_solver_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .out_valid_o, .out_ready_i, .root_plus_o, .root_minus_o, .status_o, .saturated_o
  );

  qrs_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .coef_a_i, .coef_b_i,
    .coef_c_i, .out_valid_i(out_valid_o), .out_ready_i, .root_plus_i(root_plus_o),
    .root_minus_i(root_minus_o), .status_i(status_o), .saturated_i(saturated_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver: random stalls per transaction, one long hold on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic signed [15:0] a, b, c;
    int kind;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    coef_a_i = '0;
    coef_b_i = '0;
    coef_c_i = '0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a zero, negative and zero discriminant, extremes, clipping
    send_coefs(0, 5, 3);
    send_coefs(0, -32768, 32767);
    send_coefs(1, 1, 1);
    send_coefs(1, 2, 1);
    send_coefs(-3, 12, -12);
    send_coefs(1, -3, 2);
    send_coefs(2, 0, -8);
    send_coefs(1, -32768, 0);
    send_coefs(1, 32767, 0);
    send_coefs(-1, -32768, 0);
    send_coefs(-32768, -32768, -32768);
    send_coefs(32767, 32767, 32767);
    send_coefs(-32768, 32767, 32767);
    send_coefs(32767, -32768, -32768);
    send_coefs(-32768, 0, 32767);
    send_coefs(1, 0, -32768);
    send_coefs(1, 0, 32767);
    send_coefs(-1, 0, 0);
    send_coefs(32767, 0, 0);
    send_coefs(7, -1, -1);

    // sender pause until everything has drained
    in_valid_i <= 1'b0;
    wait (pending == 0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 700) no_idle = 1'b1;
      if (i == 800) no_idle = 1'b0;
      if (i == 1000) begin
        in_valid_i <= 1'b0;
        wait (pending == 0);
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // small coefficients, mostly real roots
        a = $signed(16'($urandom_range(0, 64))) - 16'sd32;
        b = $signed(16'($urandom_range(0, 512))) - 16'sd256;
        c = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      end else if (kind < 9) begin
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
      end else begin
        a = (kind[0]) ? 16'sd0 : 16'sd1;
        b = 16'($urandom);
        c = 16'($urandom);
      end
      send_coefs(a, b, c);
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
